/* hdl/bfct_pkg.sv */
package bfct_pkg;

    localparam logic [15:0] ETH_KIND_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;

    localparam logic [1:0] ST_COUNTED = 2'd0;
    localparam logic [1:0] ST_NOT_IP  = 2'd1;
    localparam logic [1:0] ST_NOT_L4  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [15:0] ether_kind;
        logic [7:0]  ip_proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [17:0] cap_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  stream_id;
        logic        reverse_dir;
        logic        new_stream;
        logic [31:0] sum_pkts;
        logic [47:0] sum_bytes;
        logic [31:0] dir_pkts;
        logic [47:0] dir_bytes;
    } result_t;

    // classified packet held between front and back
    typedef struct packed {
        logic [1:0]  status;
        logic        is_udp;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [17:0] cap_length;
    } q_item_t;

    typedef struct packed {
        logic        is_udp;
        logic [31:0] addr_a;
        logic [15:0] port_a;
        logic [31:0] addr_b;
        logic [15:0] port_b;
        logic [31:0] pkts_ab;
        logic [47:0] bytes_ab;
        logic [31:0] pkts_ba;
        logic [47:0] bytes_ba;
    } entry_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_CMP,
        B_UPD,
        B_OUT
    } back_state_t;

endpackage

/* hdl/bfct_ram.sv */
module bfct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/bfct_front.sv */
module bfct_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bfct_pkg::in_item_t item,
    input  logic               pop,
    output logic               q_valid,
    output bfct_pkg::q_item_t  q_item
);
    import bfct_pkg::*;

    q_item_t    fifo_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    q_item_t    cls;

    // classify the incoming transaction
    always_comb
    begin
        cls.is_udp     = (item.ip_proto == PROTO_UDP);
        cls.src_addr   = item.src_addr;
        cls.dst_addr   = item.dst_addr;
        cls.sport      = item.sport;
        cls.dport      = item.dport;
        cls.cap_length = item.cap_length;
        priority if (item.ether_kind != ETH_KIND_IPV4)
            cls.status = ST_NOT_IP;
        else if (item.ip_proto != PROTO_TCP && item.ip_proto != PROTO_UDP)
            cls.status = ST_NOT_L4;
        else
            cls.status = ST_COUNTED;
    end

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = fifo_mem[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* hdl/bfct_back.sv */
module bfct_back #(
    parameter int MAX_STREAMS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  bfct_pkg::q_item_t q_item,
    output logic              pop,
    output logic              done,
    output bfct_pkg::result_t result
);
    import bfct_pkg::*;

    localparam int IDX_W = $clog2(MAX_STREAMS);
    localparam int CNT_W = $clog2(MAX_STREAMS + 1);
    localparam int SID_W = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;
    localparam int ENT_W = $bits(entry_t);

    back_state_t state_reg, state_next;
    q_item_t     item_reg, item_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    entry_t      ent_reg, ent_next;
    logic        rev_reg, rev_next;
    logic        fresh_reg, fresh_next;
    result_t     result_reg, result_next;
    logic        done_reg, done_next;

    logic        ram_we;
    logic [ENT_W-1:0] ram_rdata;
    entry_t      rd;
    logic        at_end, match_fwd, match_rev;
    logic [SID_W-1:0] sid_wide;

    bfct_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_STREAMS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg[IDX_W-1:0]),
        .wdata (ent_reg),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd     = entry_t'(ram_rdata);
    assign at_end = (idx_reg == count_reg);
    assign sid_wide = SID_W'(idx_reg) + SID_W'(1);

    // conversation match in either direction
    always_comb
    begin
        match_fwd = (rd.is_udp == item_reg.is_udp)
                 && rd.addr_a == item_reg.src_addr && rd.port_a == item_reg.sport
                 && rd.addr_b == item_reg.dst_addr && rd.port_b == item_reg.dport;
        match_rev = (rd.is_udp == item_reg.is_udp)
                 && rd.addr_a == item_reg.dst_addr && rd.port_a == item_reg.dport
                 && rd.addr_b == item_reg.src_addr && rd.port_b == item_reg.sport;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                    state_next = (q_item.status == ST_COUNTED) ? B_READ : B_IDLE;
            end
            B_READ:
            begin
                if (!at_end)
                    state_next = B_CMP;
                else if (count_reg == CNT_W'(MAX_STREAMS))
                    state_next = B_IDLE;
                else
                    state_next = B_UPD;
            end
            B_CMP:
            begin
                state_next = (match_fwd || match_rev) ? B_UPD : B_READ;
            end
            B_UPD:   state_next = B_OUT;
            B_OUT:   state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        item_next   = item_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        ent_next    = ent_reg;
        rev_next    = rev_reg;
        fresh_next  = fresh_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        pop         = 1'b0;
        ram_we      = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    pop       = 1'b1;
                    item_next = q_item;
                    idx_next  = '0;
                    if (q_item.status != ST_COUNTED)
                    begin
                        result_next        = '0;
                        result_next.status = q_item.status;
                        done_next          = 1'b1;
                    end
                end
            end
            B_READ:
            begin
                if (at_end)
                begin
                    if (count_reg == CNT_W'(MAX_STREAMS))
                    begin
                        result_next        = '0;
                        result_next.status = ST_FULL;
                        done_next          = 1'b1;
                    end
                    else
                    begin
                        ent_next        = '0;
                        ent_next.is_udp = item_reg.is_udp;
                        ent_next.addr_a = item_reg.src_addr;
                        ent_next.port_a = item_reg.sport;
                        ent_next.addr_b = item_reg.dst_addr;
                        ent_next.port_b = item_reg.dport;
                        rev_next        = 1'b0;
                        fresh_next      = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
            end
            B_CMP:
            begin
                if (match_fwd || match_rev)
                begin
                    ent_next   = rd;
                    rev_next   = !match_fwd;
                    fresh_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            B_UPD:
            begin
                if (rev_reg)
                begin
                    ent_next.pkts_ba  = ent_reg.pkts_ba + 32'd1;
                    ent_next.bytes_ba = ent_reg.bytes_ba + 48'(item_reg.cap_length);
                end
                else
                begin
                    ent_next.pkts_ab  = ent_reg.pkts_ab + 32'd1;
                    ent_next.bytes_ab = ent_reg.bytes_ab + 48'(item_reg.cap_length);
                end
            end
            B_OUT:
            begin
                ram_we                  = 1'b1;
                result_next.status      = ST_COUNTED;
                result_next.stream_id   = sid_wide[8:0];
                result_next.reverse_dir = rev_reg;
                result_next.new_stream  = fresh_reg;
                result_next.sum_pkts    = ent_reg.pkts_ab + ent_reg.pkts_ba;
                result_next.sum_bytes   = ent_reg.bytes_ab + ent_reg.bytes_ba;
                result_next.dir_pkts    = rev_reg ? ent_reg.pkts_ba : ent_reg.pkts_ab;
                result_next.dir_bytes   = rev_reg ? ent_reg.bytes_ba : ent_reg.bytes_ab;
                done_next               = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        ent_reg    <= ent_next;
        rev_reg    <= rev_next;
        fresh_reg  <= fresh_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_STREAMS))
        else $error("stream count above table size");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CMP) |-> (idx_reg < count_reg))
        else $error("table scan past last stream");

    a_counted_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_COUNTED) |-> (result.stream_id != 9'd0 || CNT_W > 8))
        else $error("counted transaction without stream id");

    a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_READ && state_next == B_UPD)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("new stream did not take a table slot");

endmodule

/* hdl/bidirectional_flow_counter_table.sv */
// a rejected transaction is reported as soon as the back end takes it; a counted one is
// compared with the stored streams in table order until one matches in either direction,
// then updated and reported; a new stream takes the next slot, a full table gives table-full
// the back end handles one transaction at a time, reading each stored stream in turn
// a two-entry queue lets start be taken while the back end works; the receiver cannot stall
// reset clears the stream count and control; the table needs no clearing pass
module bidirectional_flow_counter_table #(
    parameter int MAX_STREAMS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bfct_pkg::in_item_t item,
    output logic               done,
    output bfct_pkg::result_t  result
);
    import bfct_pkg::*;

    logic    pop;
    logic    q_valid;
    q_item_t q_item;

    // classify and queue
    bfct_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .pop     (pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    // lookup and counter update
    bfct_back #(
        .MAX_STREAMS (MAX_STREAMS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import bfct_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam longint CYCLE_LIMIT = 3000000;

    // flow table model and queue of predicted results
    class flow_scoreboard;
        int unsigned      n_streams;
        logic             t_udp[TABLE_DEPTH];
        logic [31:0]      t_addr_a[TABLE_DEPTH];
        logic [15:0]      t_port_a[TABLE_DEPTH];
        logic [31:0]      t_addr_b[TABLE_DEPTH];
        logic [15:0]      t_port_b[TABLE_DEPTH];
        logic [31:0]      t_pkts_ab[TABLE_DEPTH];
        logic [47:0]      t_bytes_ab[TABLE_DEPTH];
        logic [31:0]      t_pkts_ba[TABLE_DEPTH];
        logic [47:0]      t_bytes_ba[TABLE_DEPTH];
        result_t          pending[$];
        int unsigned      errors;
        int unsigned      n_counted;
        int unsigned      n_full;
        int unsigned      n_reverse;

        function new();
            n_streams = 0;
            errors = 0;
            n_counted = 0;
            n_full = 0;
            n_reverse = 0;
        endfunction

        // predict the result of one accepted transaction
        function void note_packet(in_item_t p);
            result_t r;
            logic    udp;
            logic    found;
            logic    rev;
            int      hit;
            r = '0;
            found = 1'b0;
            rev = 1'b0;
            hit = 0;
            if (p.ether_kind != ETH_KIND_IPV4)
            begin
                r.status = ST_NOT_IP;
            end
            else if (p.ip_proto != PROTO_TCP && p.ip_proto != PROTO_UDP)
            begin
                r.status = ST_NOT_L4;
            end
            else
            begin
                udp = (p.ip_proto == PROTO_UDP);
                for (int i = 0; i < n_streams && !found; i++)
                begin
                    if (t_udp[i] == udp)
                    begin
                        if (t_addr_a[i] == p.src_addr && t_port_a[i] == p.sport &&
                            t_addr_b[i] == p.dst_addr && t_port_b[i] == p.dport)
                        begin
                            found = 1'b1;
                            hit = i;
                        end
                        else if (t_addr_a[i] == p.dst_addr && t_port_a[i] == p.dport &&
                                 t_addr_b[i] == p.src_addr && t_port_b[i] == p.sport)
                        begin
                            found = 1'b1;
                            rev = 1'b1;
                            hit = i;
                        end
                    end
                end
                if (!found && n_streams >= TABLE_DEPTH)
                begin
                    r.status = ST_FULL;
                    n_full++;
                end
                else
                begin
                    if (!found)
                    begin
                        hit = n_streams;
                        t_udp[hit] = udp;
                        t_addr_a[hit] = p.src_addr;
                        t_port_a[hit] = p.sport;
                        t_addr_b[hit] = p.dst_addr;
                        t_port_b[hit] = p.dport;
                        t_pkts_ab[hit] = '0;
                        t_bytes_ab[hit] = '0;
                        t_pkts_ba[hit] = '0;
                        t_bytes_ba[hit] = '0;
                        n_streams++;
                        r.new_stream = 1'b1;
                    end
                    if (!rev)
                    begin
                        t_pkts_ab[hit] = t_pkts_ab[hit] + 32'd1;
                        t_bytes_ab[hit] = t_bytes_ab[hit] + 48'(p.cap_length);
                        r.dir_pkts = t_pkts_ab[hit];
                        r.dir_bytes = t_bytes_ab[hit];
                    end
                    else
                    begin
                        t_pkts_ba[hit] = t_pkts_ba[hit] + 32'd1;
                        t_bytes_ba[hit] = t_bytes_ba[hit] + 48'(p.cap_length);
                        r.dir_pkts = t_pkts_ba[hit];
                        r.dir_bytes = t_bytes_ba[hit];
                        n_reverse++;
                    end
                    r.status = ST_COUNTED;
                    r.stream_id = 9'(hit + 1);
                    r.reverse_dir = rev;
                    r.sum_pkts = t_pkts_ab[hit] + t_pkts_ba[hit];
                    r.sum_bytes = t_bytes_ab[hit] + t_bytes_ba[hit];
                    n_counted++;
                end
            end
            pending.push_back(r);
        endfunction

        // compare one result with the oldest prediction
        function void check_result(result_t got);
            result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result with nothing pending: %h", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status)
            begin
                $error("status exp %0d got %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.stream_id !== exp_r.stream_id)
            begin
                $error("stream_id exp %0d got %0d", exp_r.stream_id, got.stream_id);
                errors++;
            end
            if (got.reverse_dir !== exp_r.reverse_dir)
            begin
                $error("reverse_dir exp %0d got %0d", exp_r.reverse_dir, got.reverse_dir);
                errors++;
            end
            if (got.new_stream !== exp_r.new_stream)
            begin
                $error("new_stream exp %0d got %0d", exp_r.new_stream, got.new_stream);
                errors++;
            end
            if (got.sum_pkts !== exp_r.sum_pkts)
            begin
                $error("sum_pkts exp %h got %h", exp_r.sum_pkts, got.sum_pkts);
                errors++;
            end
            if (got.sum_bytes !== exp_r.sum_bytes)
            begin
                $error("sum_bytes exp %h got %h", exp_r.sum_bytes, got.sum_bytes);
                errors++;
            end
            if (got.dir_pkts !== exp_r.dir_pkts)
            begin
                $error("dir_pkts exp %h got %h", exp_r.dir_pkts, got.dir_pkts);
                errors++;
            end
            if (got.dir_bytes !== exp_r.dir_bytes)
            begin
                $error("dir_bytes exp %h got %h", exp_r.dir_bytes, got.dir_bytes);
                errors++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    in_item_t item;
    logic     done;
    result_t  result;
    longint   cycle_cnt = 0;

    flow_scoreboard sb;

    // small pool of endpoints so conversations repeat
    logic [31:0] pool_addr[16];
    logic [15:0] pool_port[16];

    bidirectional_flow_counter_table u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Mismatches found");
            $finish;
        end
    end

    // send one transaction, after a random gap
    task automatic send_packet(in_item_t p);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_packet(p);
    endtask

    function automatic in_item_t make_pkt(logic [15:0] ek, logic [7:0] pr,
                                          logic [31:0] sa, logic [31:0] da,
                                          logic [15:0] sp, logic [15:0] dp,
                                          logic [17:0] len);
        in_item_t p;
        p.ether_kind = ek;
        p.ip_proto = pr;
        p.src_addr = sa;
        p.dst_addr = da;
        p.sport = sp;
        p.dport = dp;
        p.cap_length = len;
        return p;
    endfunction

    // random packet, mostly well-formed and drawn from the endpoint pool
    function automatic in_item_t rand_pkt();
        in_item_t p;
        int       a;
        int       b;
        int       sel;
        a = $urandom_range(0, 15);
        b = $urandom_range(0, 15);
        sel = $urandom_range(0, 19);
        p = make_pkt(ETH_KIND_IPV4, ($urandom_range(0, 1) ? PROTO_UDP : PROTO_TCP),
                     pool_addr[a], pool_addr[b], pool_port[a], pool_port[b],
                     ($urandom_range(0, 9) == 0) ? 18'($urandom) : 18'($urandom_range(0, 1600)));
        if ($urandom_range(0, 1))
        begin
            p.src_addr = pool_addr[b];
            p.dst_addr = pool_addr[a];
            p.sport = pool_port[b];
            p.dport = pool_port[a];
        end
        if (sel == 0)
            p.ether_kind = 16'($urandom);
        else if (sel == 1)
            p.ip_proto = 8'($urandom);
        else if (sel == 2)
        begin
            p.src_addr = $urandom;
            p.dst_addr = $urandom;
            p.sport = 16'($urandom);
            p.dport = 16'($urandom);
        end
        return p;
    endfunction

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        in_item_t p;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        for (int i = 0; i < 16; i++)
        begin
            pool_addr[i] = $urandom;
            pool_port[i] = 16'($urandom);
        end
        pool_addr[0] = 32'h0;
        pool_port[0] = 16'h0;
        pool_addr[1] = 32'hFFFF_FFFF;
        pool_port[1] = 16'hFFFF;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rejects, both protocols, reverse, self-loop, extreme lengths
        send_packet(make_pkt(16'h0000, PROTO_TCP, 32'd1, 32'd2, 16'd3, 16'd4, 18'd5));
        send_packet(make_pkt(16'hFFFF, PROTO_UDP, 32'd1, 32'd2, 16'd3, 16'd4, 18'd5));
        send_packet(make_pkt(ETH_KIND_IPV4, 8'h00, 32'd1, 32'd2, 16'd3, 16'd4, 18'd5));
        send_packet(make_pkt(ETH_KIND_IPV4, 8'hFF, 32'd1, 32'd2, 16'd3, 16'd4, 18'd5));
        send_packet(make_pkt(ETH_KIND_IPV4, PROTO_TCP, 32'h0, 32'hFFFF_FFFF,
                             16'h0, 16'hFFFF, 18'h0));
        send_packet(make_pkt(ETH_KIND_IPV4, PROTO_TCP, 32'hFFFF_FFFF, 32'h0,
                             16'hFFFF, 16'h0, 18'h3FFFF));
        send_packet(make_pkt(ETH_KIND_IPV4, PROTO_UDP, 32'h0, 32'hFFFF_FFFF,
                             16'h0, 16'hFFFF, 18'h3FFFF));
        send_packet(make_pkt(ETH_KIND_IPV4, PROTO_TCP, 32'h0, 32'hFFFF_FFFF,
                             16'h0, 16'hFFFF, 18'h3FFFF));
        send_packet(make_pkt(ETH_KIND_IPV4, PROTO_UDP, 32'hA5A5_5A5A, 32'hA5A5_5A5A,
                             16'h1234, 16'h1234, 18'd64));
        send_packet(make_pkt(ETH_KIND_IPV4, PROTO_UDP, 32'hA5A5_5A5A, 32'hA5A5_5A5A,
                             16'h1234, 16'h1234, 18'd100));
        send_packet(make_pkt(ETH_KIND_IPV4, PROTO_UDP, 32'hFFFF_FFFF, 32'h0,
                             16'hFFFF, 16'h0, 18'd1));

        // pause until everything has come back
        drain();

        // random traffic over the endpoint pool
        for (int n = 0; n < 950; n++)
            send_packet(rand_pkt());
        drain();

        // fill the table with fresh conversations, then hit it while full
        while (sb.n_streams < TABLE_DEPTH)
            send_packet(make_pkt(ETH_KIND_IPV4, PROTO_TCP, $urandom, $urandom,
                                 16'($urandom), 16'($urandom), 18'($urandom)));
        for (int n = 0; n < 80; n++)
        begin
            p = rand_pkt();
            if ($urandom_range(0, 2) == 0)
                p = make_pkt(ETH_KIND_IPV4, PROTO_UDP, $urandom, $urandom,
                             16'($urandom), 16'($urandom), 18'($urandom));
            send_packet(p);
        end

        drain();
        $display("%0d counted, %0d reverse, %0d table-full, %0d streams stored",
                 sb.n_counted, sb.n_reverse, sb.n_full, sb.n_streams);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
